// ===== hw/rtl/cpurb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the register and branch execute block:
// instruction selector codes, status flag bit positions, reset values.
// No dependencies.
package cpurb_pkg;

    // Instruction selector codes
    localparam logic [5:0] OP_CLC = 6'd0;
    localparam logic [5:0] OP_CLD = 6'd1;
    localparam logic [5:0] OP_CLI = 6'd2;
    localparam logic [5:0] OP_CLV = 6'd3;
    localparam logic [5:0] OP_SEC = 6'd4;
    localparam logic [5:0] OP_SED = 6'd5;
    localparam logic [5:0] OP_SEI = 6'd6;
    localparam logic [5:0] OP_REP = 6'd7;
    localparam logic [5:0] OP_SEP = 6'd8;
    localparam logic [5:0] OP_INA = 6'd9;
    localparam logic [5:0] OP_INX = 6'd10;
    localparam logic [5:0] OP_INY = 6'd11;
    localparam logic [5:0] OP_DEA = 6'd12;
    localparam logic [5:0] OP_DEX = 6'd13;
    localparam logic [5:0] OP_DEY = 6'd14;
    localparam logic [5:0] OP_TAX = 6'd15;
    localparam logic [5:0] OP_TAY = 6'd16;
    localparam logic [5:0] OP_TCS = 6'd17;
    localparam logic [5:0] OP_TCD = 6'd18;
    localparam logic [5:0] OP_TDC = 6'd19;
    localparam logic [5:0] OP_TSC = 6'd20;
    localparam logic [5:0] OP_TSX = 6'd21;
    localparam logic [5:0] OP_TXA = 6'd22;
    localparam logic [5:0] OP_TXS = 6'd23;
    localparam logic [5:0] OP_TXY = 6'd24;
    localparam logic [5:0] OP_TYA = 6'd25;
    localparam logic [5:0] OP_TYX = 6'd26;
    localparam logic [5:0] OP_XBA = 6'd27;
    localparam logic [5:0] OP_XCE = 6'd28;
    localparam logic [5:0] OP_NOP = 6'd29;
    localparam logic [5:0] OP_WDM = 6'd30;
    localparam logic [5:0] OP_BCC = 6'd31;
    localparam logic [5:0] OP_BCS = 6'd32;
    localparam logic [5:0] OP_BEQ = 6'd33;
    localparam logic [5:0] OP_BMI = 6'd34;
    localparam logic [5:0] OP_BNE = 6'd35;
    localparam logic [5:0] OP_BPL = 6'd36;
    localparam logic [5:0] OP_BVC = 6'd37;
    localparam logic [5:0] OP_BVS = 6'd38;
    localparam logic [5:0] OP_BRA = 6'd39;
    localparam logic [5:0] OP_BRL = 6'd40;

    // Status flag bit positions
    localparam int FL_N = 7;
    localparam int FL_V = 6;
    localparam int FL_M = 5;
    localparam int FL_X = 4;
    localparam int FL_D = 3;
    localparam int FL_I = 2;
    localparam int FL_Z = 1;
    localparam int FL_C = 0;

    // Emulation mode masks M and X out of REP/SEP
    localparam logic [7:0] EMU_PSR_MASK = 8'hCF;
    localparam logic [7:0] STACK_PAGE   = 8'h01;

    localparam logic [15:0] SP_RESET    = 16'h01FF;
    localparam logic [7:0]  FLAGS_RESET = 8'h34;

    localparam logic [2:0] CYC_BASE  = 3'd2;
    localparam logic [2:0] CYC_TAKEN = 3'd3;
    localparam logic [2:0] CYC_LONG  = 3'd4;

    // Update N and Z from a value at 8 or 16 bits
    function automatic logic [7:0] set_nz(input logic [7:0] f, input logic [15:0] v,
                                          input logic wide);
        logic [7:0] r;
        r = f;
        r[FL_N] = wide ? v[15] : v[7];
        r[FL_Z] = wide ? (v == 16'h0000) : (v[7:0] == 8'h00);
        return r;
    endfunction

endpackage

// ===== hw/rtl/cpu_register_and_branch_execute.sv =====
`timescale 1ns / 1ps
// Register and branch execute unit: holds the architectural registers and
// runs one flag/transfer/inc-dec/branch instruction per transaction.
// Depends on cpurb_pkg.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+---------------------------------------
//  in      | in_valid  | in_ready  | opcode, operand_value
//  out     | out_valid | out_ready | acc_out x_out y_out stack_out
//          |           |           | direct_out pc_out flags_out emu_out
//          |           |           | cycles_used
//
// Two register stages: an input register, then the architectural registers
// together with the result register. An accepted transaction waits in the
// input register, then executes into stage 2, which raises out_valid; one
// transaction per cycle is sustained while the output is not stalled, the
// execute logic reading the registers that the previous transaction just wrote.
// A stalled output holds stage 2; stage 1 takes one more transaction, then
// in_ready drops until the result is taken.
// Reset: A/X/Y/D/PC zero, S = 0x01FF, P = 0x34 (M, X, I), emulation on.
module cpu_register_and_branch_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  opcode,
    input  logic [15:0] operand_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] acc_out,
    output logic [15:0] x_out,
    output logic [15:0] y_out,
    output logic [15:0] stack_out,
    output logic [15:0] direct_out,
    output logic [15:0] pc_out,
    output logic [7:0]  flags_out,
    output logic        emu_out,
    output logic [2:0]  cycles_used
);
    import cpurb_pkg::*;

    // Stage 1: input register
    logic        s1_valid_reg;
    logic [5:0]  op_reg;
    logic [15:0] opv_reg;

    // Stage 2: architectural state doubles as the result register; it only
    // changes when a transaction moves into the output slot.
    logic        out_valid_reg;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] dp_reg, dp_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  p_reg, p_next;
    logic        e_reg, e_next;
    logic [2:0]  cyc_reg, cyc_next;

    logic advance;   // stage 1 item executes and lands in the output slot

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            op_reg  <= opcode;
            opv_reg <= operand_value;
        end
    end

    // Execute
    always_comb begin
        logic        as, xs, take;
        logic [7:0]  lo, m;
        logic [15:0] after, off, v;

        as    = e_reg || p_reg[FL_M];
        xs    = e_reg || p_reg[FL_X];
        lo    = opv_reg[7:0];
        after = pc_reg + 16'd2;
        off   = {{8{lo[7]}}, lo};
        m     = e_reg ? (lo & EMU_PSR_MASK) : lo;
        v     = 16'h0000;

        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        sp_next  = sp_reg;
        dp_next  = dp_reg;
        pc_next  = pc_reg + 16'd1;
        p_next   = p_reg;
        e_next   = e_reg;
        cyc_next = CYC_BASE;

        case (op_reg)
            OP_BCC:  take = !p_reg[FL_C];
            OP_BCS:  take = p_reg[FL_C];
            OP_BEQ:  take = p_reg[FL_Z];
            OP_BMI:  take = p_reg[FL_N];
            OP_BNE:  take = !p_reg[FL_Z];
            OP_BPL:  take = !p_reg[FL_N];
            OP_BVC:  take = !p_reg[FL_V];
            OP_BVS:  take = p_reg[FL_V];
            OP_BRA:  take = 1'b1;
            default: take = 1'b0;
        endcase

        case (op_reg)
            OP_CLC: p_next[FL_C] = 1'b0;
            OP_CLD: p_next[FL_D] = 1'b0;
            OP_CLI: p_next[FL_I] = 1'b0;
            OP_CLV: p_next[FL_V] = 1'b0;
            OP_SEC: p_next[FL_C] = 1'b1;
            OP_SED: p_next[FL_D] = 1'b1;
            OP_SEI: p_next[FL_I] = 1'b1;
            OP_REP, OP_SEP: begin
                p_next = (op_reg == OP_REP) ? (p_reg & ~m) : (p_reg | m);
                // short index in native mode drops the index high bytes
                if (!e_reg && p_next[FL_X]) begin
                    x_next = {8'h00, x_reg[7:0]};
                    y_next = {8'h00, y_reg[7:0]};
                end
                pc_next  = after;
                cyc_next = CYC_TAKEN;
            end
            OP_INA, OP_DEA: begin
                v = (op_reg == OP_INA) ? (acc_reg + 16'd1) : (acc_reg - 16'd1);
                acc_next = as ? {acc_reg[15:8], v[7:0]} : v;
                p_next   = set_nz(p_reg, acc_next, !as);
            end
            OP_INX, OP_DEX, OP_TAX, OP_TSX, OP_TYX: begin
                case (op_reg)
                    OP_INX:  v = x_reg + 16'd1;
                    OP_DEX:  v = x_reg - 16'd1;
                    OP_TAX:  v = acc_reg;
                    OP_TSX:  v = sp_reg;
                    default: v = y_reg;
                endcase
                x_next = xs ? {8'h00, v[7:0]} : v;
                p_next = set_nz(p_reg, x_next, !xs);
            end
            OP_INY, OP_DEY, OP_TAY, OP_TXY: begin
                case (op_reg)
                    OP_INY:  v = y_reg + 16'd1;
                    OP_DEY:  v = y_reg - 16'd1;
                    OP_TAY:  v = acc_reg;
                    default: v = x_reg;
                endcase
                y_next = xs ? {8'h00, v[7:0]} : v;
                p_next = set_nz(p_reg, y_next, !xs);
            end
            OP_TCS: sp_next = e_reg ? {STACK_PAGE, acc_reg[7:0]} : acc_reg;
            OP_TCD: begin
                dp_next = acc_reg;
                p_next  = set_nz(p_reg, acc_reg, 1'b1);
            end
            OP_TDC: begin
                acc_next = dp_reg;
                p_next   = set_nz(p_reg, dp_reg, 1'b1);
            end
            OP_TSC: begin
                acc_next = e_reg ? {STACK_PAGE, sp_reg[7:0]} : sp_reg;
                p_next   = set_nz(p_reg, acc_next, 1'b1);
            end
            OP_TXA, OP_TYA: begin
                v = (op_reg == OP_TXA) ? x_reg : y_reg;
                // short accumulator keeps its high byte
                if (as) begin
                    acc_next = {acc_reg[15:8], v[7:0]};
                end
                else begin
                    acc_next = xs ? {8'h00, v[7:0]} : v;
                end
                p_next = set_nz(p_reg, acc_next, !as);
            end
            OP_TXS: begin
                if (e_reg) begin
                    sp_next = {STACK_PAGE, x_reg[7:0]};
                end
                else begin
                    sp_next = xs ? {8'h00, x_reg[7:0]} : x_reg;
                end
            end
            OP_XBA: begin
                acc_next = {acc_reg[7:0], acc_reg[15:8]};
                p_next   = set_nz(p_reg, acc_next, 1'b0);
                cyc_next = CYC_TAKEN;
            end
            OP_XCE: begin
                e_next       = p_reg[FL_C];
                p_next[FL_C] = e_reg;
                if (p_reg[FL_C]) begin
                    p_next[FL_M] = 1'b1;
                    p_next[FL_X] = 1'b1;
                    x_next       = {8'h00, x_reg[7:0]};
                    y_next       = {8'h00, y_reg[7:0]};
                    sp_next      = {STACK_PAGE, sp_reg[7:0]};
                end
            end
            OP_WDM: pc_next = after;
            OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE,
            OP_BPL, OP_BVC, OP_BVS, OP_BRA: begin
                pc_next = after;
                if (take) begin
                    pc_next  = after + off;
                    cyc_next = CYC_TAKEN;
                    // page-cross penalty in emulation only
                    if (e_reg && (pc_next[15:8] != after[15:8])) begin
                        cyc_next = CYC_LONG;
                    end
                end
            end
            OP_BRL: begin
                pc_next  = pc_reg + 16'd3 + opv_reg;
                cyc_next = CYC_LONG;
            end
            default: ;   // NOP and unused selectors
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            acc_reg       <= 16'h0000;
            x_reg         <= 16'h0000;
            y_reg         <= 16'h0000;
            sp_reg        <= SP_RESET;
            dp_reg        <= 16'h0000;
            pc_reg        <= 16'h0000;
            p_reg         <= FLAGS_RESET;
            e_reg         <= 1'b1;
        end
        else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                x_reg         <= x_next;
                y_reg         <= y_next;
                sp_reg        <= sp_next;
                dp_reg        <= dp_next;
                pc_reg        <= pc_next;
                p_reg         <= p_next;
                e_reg         <= e_next;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            cyc_reg <= cyc_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign acc_out     = acc_reg;
    assign x_out       = x_reg;
    assign y_out       = y_reg;
    assign stack_out   = sp_reg;
    assign direct_out  = dp_reg;
    assign pc_out      = pc_reg;
    assign flags_out   = p_reg;
    assign emu_out     = e_reg;
    assign cycles_used = cyc_reg;

`ifndef SYNTHESIS
    // Emulation mode pins the stack to page one and forces M and X.
    a_emu_state: assert property (@(posedge clk) disable iff (!rst_n)
        e_reg |-> (sp_reg[15:8] == STACK_PAGE) && p_reg[FL_M] && p_reg[FL_X])
        else $error("emulation state invariant broken");

    // Short index registers never carry a high byte.
    a_short_index: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg[FL_X] |-> (x_reg[15:8] == 8'h00) && (y_reg[15:8] == 8'h00))
        else $error("index high byte set with X flag");

    // Reported cost stays one of CYC_BASE, CYC_TAKEN and CYC_LONG.
    a_cycle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cyc_reg == CYC_BASE) || (cyc_reg == CYC_TAKEN)
                          || (cyc_reg == CYC_LONG))
        else $error("cycle count out of range");

    // State moves only when a transaction executes.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pc_reg) && $stable(p_reg) && $stable(acc_reg))
        else $error("architectural state changed without a transaction");
`endif

endmodule
